// File: hdl/slcp_pkg.sv
`default_nettype none
package slcp_pkg;

  localparam int unsigned TOKEN_MAX = 5;
  localparam logic [11:0] CENTER_COUNT = 12'd3000;
  localparam logic [15:0] COUNT_BASE = 16'd27000;
  localparam logic [15:0] ANGLE_SCALE = 16'd100;
  localparam logic [11:0] ANGLE_MAX = 12'd90;
  // floor(x / 9) == (x * RECIP_NINE) >> RECIP_SHIFT for x up to 36000
  localparam logic [16:0] RECIP_NINE = 17'd116509;
  localparam int unsigned RECIP_SHIFT = 20;

  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_TWO = 8'h32;

  localparam logic RESP_ACK = 1'b0;
  localparam logic RESP_INVALID = 1'b1;

  typedef logic [TOKEN_MAX-1:0][7:0] tok_t;

  typedef struct packed {
    logic ok;
    logic is_servo;
    logic [1:0] index;
    logic [11:0] count;
    logic led_on;
  } chk_t;

  function automatic logic slcp_is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage
`default_nettype wire

// File: hdl/servo_led_command_parser.sv
`default_nettype none
// Command parser for three servo pulse counts and two LEDs.
// Input channel: one received byte per transaction on rx_byte (in_valid /
// in_ready). Whitespace ends a token; up to five bytes of a token are kept.
// Output channel: one transaction per token end (out_valid / out_ready),
// carrying response (0 ack, 1 invalid) and the counts and LED states held
// after that token. Whitespace outside a token and token bytes give nothing.
// Latency: the result is presented the cycle after the ending whitespace
// byte is accepted. Throughput: one byte per cycle while in_ready is high;
// the check logic and divide-by-nine multiply lie after the token buffer.
// Reset: no token open, servo counts 3000, LEDs off, output empty.
// Stall: in_ready is high while the output register is empty or being
// taken, so bytes keep flowing until a result waits unread; then
// in_ready drops until out_ready takes it.
module servo_led_command_parser import slcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             response,
  output logic [11:0]      servo_zero_count,
  output logic [11:0]      servo_one_count,
  output logic [11:0]      servo_two_count,
  output logic             led_zero_on,
  output logic             led_one_on
);

  logic             in_acc, is_ws, in_token, emit, apply;
  tok_t             bytes;
  chk_t             chk;
  logic [2:0][11:0] servo, servo_next;
  logic [1:0]       leds, leds_next;
  logic             out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign in_acc = in_valid && in_ready;
  assign is_ws = slcp_is_space(rx_byte);
  assign emit = in_acc && is_ws && in_token;
  assign apply = emit && chk.ok;

  slcp_token u_token (
    .clk      (clk),
    .rst      (rst),
    .acc      (in_acc),
    .is_ws    (is_ws),
    .rx_byte  (rx_byte),
    .in_token (in_token),
    .bytes    (bytes)
  );

  slcp_check u_check (
    .bytes (bytes),
    .chk   (chk)
  );

  always_comb begin
    servo_next = servo;
    leds_next = leds;
    if (apply) begin
      if (chk.is_servo) begin
        servo_next[chk.index] = chk.count;
      end else begin
        leds_next[chk.index[0]] = chk.led_on;
      end
    end
    out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo <= {3{CENTER_COUNT}};
      leds <= '0;
      out_valid <= 1'b0;
    end else begin
      servo <= servo_next;
      leds <= leds_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      response <= chk.ok ? RESP_ACK : RESP_INVALID;
      servo_zero_count <= servo_next[0];
      servo_one_count <= servo_next[1];
      servo_two_count <= servo_next[2];
      led_zero_on <= leds_next[0];
      led_one_on <= leds_next[1];
    end
  end

`ifndef ASSERT_OFF
  a_emit_shows: assert property (@(posedge clk) disable iff (rst) emit |=> out_valid)
    else $error("token end did not produce a result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !is_ws && !(out_valid && out_ready)) |=> $stable(out_valid))
    else $error("result valid changed without a token end or take");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (servo[0] >= 12'd2000) && (servo[0] <= 12'd4000) &&
    (servo[1] >= 12'd2000) && (servo[1] <= 12'd4000) &&
    (servo[2] >= 12'd2000) && (servo[2] <= 12'd4000))
    else $error("servo count out of range");
  a_invalid_holds: assert property (@(posedge clk) disable iff (rst)
    (emit && !chk.ok) |=> ($stable(servo) && $stable(leds)))
    else $error("invalid token changed state");
`endif

endmodule
`default_nettype wire

// File: hdl/slcp_token.sv
`default_nettype none
module slcp_token import slcp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       acc,
  input  wire logic       is_ws,
  input  wire logic [7:0] rx_byte,
  output logic            in_token,
  output tok_t            bytes
);

  logic [2:0] length;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token <= 1'b0;
      length <= '0;
    end else if (acc) begin
      if (is_ws) begin
        in_token <= 1'b0;
      end else if (!in_token) begin
        in_token <= 1'b1;
        length <= 3'd1;
      end else if (length < 3'(TOKEN_MAX)) begin
        length <= length + 3'd1;
      end
    end
  end

  // token start clears the buffer so short tokens read zero past the end
  always_ff @(posedge clk) begin
    if (acc && !is_ws) begin
      if (!in_token) begin
        bytes <= tok_t'(rx_byte);
      end else if (length < 3'(TOKEN_MAX)) begin
        bytes[length] <= rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/slcp_check.sv
`default_nettype none
module slcp_check import slcp_pkg::*; (
  input  tok_t bytes,
  output chk_t chk
);

  logic signed [8:0]  d3, d4;
  logic signed [11:0] d3x, d4x, angle;
  logic               angle_ok, sign_ok, servo_ok, led_idx_ok, on, off;
  logic [15:0]        scaled, x;
  logic [32:0]        prod;

  // digit math on signed bytes, so non-digits can still land in range
  assign d3 = $signed({bytes[3][7], bytes[3]}) - $signed(9'(CH_ZERO));
  assign d4 = $signed({bytes[4][7], bytes[4]}) - $signed(9'(CH_ZERO));
  assign d3x = {{3{d3[8]}}, d3};
  assign d4x = {{3{d4[8]}}, d4};
  assign angle = d3x * 12'sd10 + d4x;
  assign angle_ok = !angle[11] && (angle <= $signed(ANGLE_MAX));

  assign scaled = 16'(angle[6:0]) * ANGLE_SCALE;
  assign x = (bytes[2] == CH_MINUS) ? COUNT_BASE - scaled : COUNT_BASE + scaled;
  assign prod = 33'(x) * 33'(RECIP_NINE);

  assign sign_ok = (bytes[2] == CH_PLUS) || (bytes[2] == CH_MINUS);
  assign servo_ok = (bytes[1] == CH_ZERO) || (bytes[1] == CH_ONE) || (bytes[1] == CH_TWO);
  assign led_idx_ok = (bytes[1] == CH_ZERO) || (bytes[1] == CH_ONE);
  assign on = (bytes[2] == CH_O) && (bytes[3] == CH_N) && (bytes[4] == CH_N);
  assign off = (bytes[2] == CH_O) && (bytes[3] == CH_F) && (bytes[4] == CH_F);

  always_comb begin
    chk.is_servo = (bytes[0] == CH_S);
    chk.index = bytes[1][1:0];
    chk.count = prod[RECIP_SHIFT+11:RECIP_SHIFT];
    chk.led_on = on;
    if (bytes[0] == CH_S) begin
      chk.ok = servo_ok && sign_ok && angle_ok;
    end else if (bytes[0] == CH_L) begin
      chk.ok = led_idx_ok && (on || off);
    end else begin
      chk.ok = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: verif/testbench.sv
module testbench;
  import slcp_pkg::*;

  localparam int DIGIT_BASE = int'(CH_ZERO);
  localparam int COUNT_DIVISOR = 9;
  localparam int BYTE_TARGET = 1600;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic        response;
    logic [11:0] servo_zero;
    logic [11:0] servo_one;
    logic [11:0] servo_two;
    logic        led_zero;
    logic        led_one;
  } status_t;

  typedef enum {RX_FREE, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        response;
  logic [11:0] servo_zero_count;
  logic [11:0] servo_one_count;
  logic [11:0] servo_two_count;
  logic        led_zero_on;
  logic        led_one_on;

  servo_led_command_parser DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .response         (response),
    .servo_zero_count (servo_zero_count),
    .servo_one_count  (servo_one_count),
    .servo_two_count  (servo_two_count),
    .led_zero_on      (led_zero_on),
    .led_one_on       (led_one_on)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // parser state as seen from outside
  logic        token_open = 1'b0;
  int          token_fill = 0;
  logic [7:0]  token_buf [TOKEN_MAX];
  logic [11:0] servo_count [3] = '{CENTER_COUNT, CENTER_COUNT, CENTER_COUNT};
  logic [1:0]  led_bits = 2'b00;

  logic [7:0]  pending_bytes [$];
  status_t     expected_status [$];
  status_t     want;
  logic        in_taken;
  int          error_count = 0;
  int          idle_cycles = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_mode_left = 0;
  int          rx_period = 4;
  int          rx_phase = 0;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic int signed_char(input logic [7:0] b);
    return int'($signed(b));
  endfunction

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] led_letter();
    case ($urandom_range(0, 2))
      0: return CH_O;
      1: return CH_N;
      default: return CH_F;
    endcase
  endfunction

  // Advance the parser by one accepted byte; a blank that closes a token
  // yields one status transaction.
  task automatic track_byte(input logic [7:0] b);
    status_t st;
    int sel;
    int ang;
    logic ok;
    if (!is_blank(b)) begin
      if (!token_open) begin
        token_open = 1'b1;
        token_fill = 0;
        foreach (token_buf[i]) token_buf[i] = 8'h00;
      end
      if (token_fill < TOKEN_MAX) begin
        token_buf[token_fill] = b;
        token_fill++;
      end
    end else if (token_open) begin
      token_open = 1'b0;
      ok = 1'b0;
      sel = signed_char(token_buf[1]) - DIGIT_BASE;
      if (token_buf[0] == CH_S) begin
        if (sel >= 0 && sel <= 2 && (token_buf[2] == CH_PLUS || token_buf[2] == CH_MINUS)) begin
          ang = 10 * (signed_char(token_buf[3]) - DIGIT_BASE)
              + (signed_char(token_buf[4]) - DIGIT_BASE);
          if (ang >= 0 && ang <= int'(ANGLE_MAX)) begin
            if (token_buf[2] == CH_MINUS) ang = -ang;
            servo_count[sel] = 12'((int'(COUNT_BASE) + int'(ANGLE_SCALE) * ang) / COUNT_DIVISOR);
            ok = 1'b1;
          end
        end
      end else if (token_buf[0] == CH_L) begin
        if ((sel == 0 || sel == 1) && token_buf[2] == CH_O) begin
          if (token_buf[3] == CH_N && token_buf[4] == CH_N) begin
            led_bits[sel] = 1'b1;
            ok = 1'b1;
          end else if (token_buf[3] == CH_F && token_buf[4] == CH_F) begin
            led_bits[sel] = 1'b0;
            ok = 1'b1;
          end
        end
      end
      st.response = ok ? RESP_ACK : RESP_INVALID;
      st.servo_zero = servo_count[0];
      st.servo_one = servo_count[1];
      st.servo_two = servo_count[2];
      st.led_zero = led_bits[0];
      st.led_one = led_bits[1];
      expected_status.push_back(st);
    end
  endtask

  task automatic push_token(input string s, input logic [7:0] sep);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(8'(s[i]));
    pending_bytes.push_back(sep);
  endtask

  // Mostly well-formed servo and LED commands with random content, plus
  // truncated, overlong, corrupted and junk tokens.
  task automatic queue_random_token();
    logic [7:0] tok [$];
    int kind;
    int r;
    int ang;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      tok.push_back(CH_S);
      tok.push_back(($urandom_range(0, 7) == 0) ? any_char()
                                                : 8'(DIGIT_BASE + $urandom_range(0, 2)));
      r = $urandom_range(0, 7);
      tok.push_back((r == 0) ? any_char() : (r[0] ? CH_PLUS : CH_MINUS));
      r = $urandom_range(0, 9);
      if (r <= 7) begin
        ang = (r < 7) ? $urandom_range(0, 90) : $urandom_range(91, 99);
        tok.push_back(8'(DIGIT_BASE + ang / 10));
        tok.push_back(8'(DIGIT_BASE + ang % 10));
      end else if (r == 8) begin
        // random printable units byte, may still land in range
        tok.push_back(8'(DIGIT_BASE + $urandom_range(0, 9)));
        tok.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else begin
        tok.push_back(any_char());
        tok.push_back(any_char());
      end
    end else if (kind <= 8) begin
      tok.push_back(CH_L);
      r = $urandom_range(0, 7);
      if (r == 0) tok.push_back(any_char());
      else if (r == 1) tok.push_back(CH_TWO);
      else tok.push_back(8'(DIGIT_BASE + (r & 1)));
      if ($urandom_range(0, 3) == 0) begin
        repeat (3) tok.push_back(led_letter());
      end else if ($urandom_range(0, 1) == 1) begin
        tok.push_back(CH_O);
        tok.push_back(CH_N);
        tok.push_back(CH_N);
      end else begin
        tok.push_back(CH_O);
        tok.push_back(CH_F);
        tok.push_back(CH_F);
      end
    end else begin
      repeat ($urandom_range(1, 8)) tok.push_back(any_char());
    end
    r = $urandom_range(0, 15);
    if (r == 0 && tok.size() > 1) begin
      cut = $urandom_range(1, tok.size() - 1);
      while (tok.size() > cut) void'(tok.pop_back());
    end else if (r == 1) begin
      repeat ($urandom_range(1, 4)) tok.push_back(any_char());
    end else if (r == 2) begin
      tok[$urandom_range(0, tok.size() - 1)] = any_char();
    end
    foreach (tok[i]) pending_bytes.push_back(tok[i]);
    pending_bytes.push_back(blank_char());
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(blank_char());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    out_ready = 1'b0;
    foreach (token_buf[i]) token_buf[i] = 8'h00;

    pending_bytes.push_back(8'h20);
    pending_bytes.push_back(8'h09);
    push_token("S0+90", 8'h20);
    push_token("S2-90", 8'h09);
    push_token("L1ONN", 8'h0D);
    push_token("L1OFF", 8'h0A);
    push_token("S1+9", 8'h0B);     // short: missing units byte reads as zero
    push_token("L0ONNXY", 8'h0C);  // overlong: tail ignored
    push_token("S0+5+", 8'h20);    // '+' as units digit still lands in range
    push_token("X", 8'h20);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h20);
    while (pending_bytes.size() < BYTE_TARGET) queue_random_token();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || expected_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until the transaction completes
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
      end
      rx_byte <= pending_bytes.pop_front();
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left == 0) begin
        gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: switches at random between stall patterns
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 300);
      rx_period = $urandom_range(2, 16);
    end else begin
      rx_mode_left--;
    end
    rx_phase = (rx_phase + 1) % rx_period;
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_phase >= rx_period / 2);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: predicts on accepted bytes, checks each status transaction
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) track_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("status transaction with none outstanding");
          error_count++;
        end else begin
          want = expected_status.pop_front();
          if (response !== want.response) begin
            $error("response: expected %0d, got %0d", want.response, response);
            error_count++;
          end
          if (servo_zero_count !== want.servo_zero) begin
            $error("servo_zero_count: expected %0d, got %0d", want.servo_zero, servo_zero_count);
            error_count++;
          end
          if (servo_one_count !== want.servo_one) begin
            $error("servo_one_count: expected %0d, got %0d", want.servo_one, servo_one_count);
            error_count++;
          end
          if (servo_two_count !== want.servo_two) begin
            $error("servo_two_count: expected %0d, got %0d", want.servo_two, servo_two_count);
            error_count++;
          end
          if (led_zero_on !== want.led_zero) begin
            $error("led_zero_on: expected %0d, got %0d", want.led_zero, led_zero_on);
            error_count++;
          end
          if (led_one_on !== want.led_one) begin
            $error("led_one_on: expected %0d, got %0d", want.led_one, led_one_on);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
